/* src/round_robin_quantum_scheduler_unit_macros.svh */
// assertion macros for the round-robin quantum scheduler checker
// no dependencies; included by the checker file
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_UNIT_MACROS_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_UNIT_MACROS_SVH

// same-cycle implication
`define RRQS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RRQS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/rrqs_pkg.sv */
// shared types and codes for the round-robin quantum scheduler
// no dependencies
package rrqs_pkg;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    localparam logic [1:0] EV_RUN  = 2'd0;
    localparam logic [1:0] EV_IDLE = 2'd1;
    localparam logic [1:0] EV_END  = 2'd2;
    localparam logic [1:0] EV_NONE = 2'd3;

    localparam logic [15:0] QUANTUM_RESET = 16'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] arr_time;
        logic [15:0] bur_time;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [20:0] event_time;
        logic [3:0]  job_index;
        logic [15:0] slice_length;
        logic        job_finished;
        logic [20:0] done_time;
        logic [20:0] tat_time;
        logic [20:0] wait_time;
    } evt_item_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic res_none;
        logic start_set;
        logic end_res;
        logic idle_set;
        logic pop_rd;
        logic pop_j;
        logic slice_set;
        logic tat_set;
        logic wt_set;
        logic scan_run;
        logic push_j;
        logic emit;
    } ctl_t;

    typedef struct packed {
        logic no_jobs;
        logic started;
        logic all_done;
        logic q_empty;
        logic start_pos;
        logic slice_fin;
        logic scan_done;
        logic out_busy;
    } sts_t;

endpackage

/* src/rrqs_ctrl.sv */
// controller state machine of the round-robin quantum scheduler
// depends on rrqs_pkg
module rrqs_ctrl (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    input  logic [1:0]   req_opcode,
    input  rrqs_pkg::sts_t sts,
    output logic         req_stall,
    output rrqs_pkg::ctl_t ctl
);
    import rrqs_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_START  = 10'b0000000010,
        ST_DECIDE = 10'b0000000100,
        ST_POP    = 10'b0000001000,
        ST_SLICE  = 10'b0000010000,
        ST_TAT    = 10'b0000100000,
        ST_WT     = 10'b0001000000,
        ST_SCAN   = 10'b0010000000,
        ST_PUSHJ  = 10'b0100000000,
        ST_EMIT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   after_decide_reg, after_decide_next;
    logic   after_push_reg, after_push_next;

    assign req_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        ctl               = '0;
        state_next        = state_reg;
        after_decide_next = after_decide_reg;
        after_push_next   = after_push_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req_opcode)
                        OP_LOAD:  ctl.load = 1'b1;
                        OP_CLEAR: ctl.clear = 1'b1;
                        OP_STEP:
                        begin
                            priority if (sts.no_jobs)
                            begin
                                ctl.res_none = 1'b1;
                                state_next   = ST_EMIT;
                            end
                            else if (!sts.started)
                                state_next = ST_START;
                            else
                                state_next = ST_DECIDE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_START:
            begin
                ctl.start_set     = 1'b1;
                after_decide_next = !sts.start_pos;
                after_push_next   = 1'b0;
                state_next        = ST_SCAN;
            end
            ST_DECIDE:
            begin
                priority if (sts.all_done)
                begin
                    ctl.end_res = 1'b1;
                    state_next  = ST_EMIT;
                end
                else if (sts.q_empty)
                begin
                    ctl.idle_set      = 1'b1;
                    after_decide_next = 1'b0;
                    after_push_next   = 1'b0;
                    state_next        = ST_SCAN;
                end
                else
                begin
                    ctl.pop_rd = 1'b1;
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                ctl.pop_j  = 1'b1;
                state_next = ST_SLICE;
            end
            ST_SLICE:
            begin
                ctl.slice_set     = 1'b1;
                after_decide_next = 1'b0;
                after_push_next   = !sts.slice_fin;
                state_next        = sts.slice_fin ? ST_TAT : ST_SCAN;
            end
            ST_TAT:
            begin
                ctl.tat_set = 1'b1;
                state_next  = ST_WT;
            end
            ST_WT:
            begin
                ctl.wt_set = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                ctl.scan_run = 1'b1;
                if (sts.scan_done)
                begin
                    priority if (after_decide_reg)
                        state_next = ST_DECIDE;
                    else if (after_push_reg)
                        state_next = ST_PUSHJ;
                    else
                        state_next = ST_EMIT;
                end
            end
            ST_PUSHJ:
            begin
                ctl.push_j = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!sts.out_busy)
                begin
                    ctl.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            after_decide_reg <= 1'b0;
            after_push_reg   <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            after_decide_reg <= after_decide_next;
            after_push_reg   <= after_push_next;
        end
    end

endmodule

/* src/rrqs_datapath.sv */
// job tables, ready queue, time keeping and result registers of the scheduler
// depends on rrqs_pkg; driven by rrqs_ctrl
module rrqs_datapath #(
    parameter int MAX_JOBS  = 16,
    parameter int TIME_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rrqs_pkg::req_item_t req_item,
    input  rrqs_pkg::ctl_t    ctl,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data,
    input  logic              evt_stall,
    output rrqs_pkg::sts_t    sts,
    output logic              evt_valid,
    output rrqs_pkg::evt_item_t evt_item
);
    import rrqs_pkg::*;

    localparam int TW   = (TIME_BITS < 16) ? TIME_BITS : 16;
    localparam int JW   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW   = $clog2(MAX_JOBS + 1);
    localparam int CT_W = TW + $clog2(MAX_JOBS + 1);

    logic [TW-1:0] arr_mem  [MAX_JOBS];
    logic [TW-1:0] bur_mem  [MAX_JOBS];
    logic [TW-1:0] rem_mem  [MAX_JOBS];
    logic [JW-1:0] fifo_mem [MAX_JOBS];

    logic [TW-1:0]   arr_q, bur_q, rem_q;
    logic [JW-1:0]   fifo_q;
    logic [CT_W-1:0] ct_reg, lo_reg, hi_reg, tat_reg;
    logic            lo_incl_reg, started_reg, pend_reg, out_valid_reg;
    logic [CW-1:0]   loaded_reg, completed_reg, count_reg, scan_idx_reg;
    logic [JW-1:0]   head_reg, pidx_reg, j_reg;
    logic [15:0]     quantum_reg;
    logic [TW-1:0]   arr_j_reg, bur_j_reg;
    evt_item_t       res_reg, out_reg;

    logic [JW-1:0]   arr_addr, tail, head_inc;
    logic [JW:0]     tail_sum;
    logic            load_en, win_hit, push_en, scan_more;
    logic [JW-1:0]   push_idx;
    logic [15:0]     qe, rem16, e;
    logic [CT_W-1:0] ct_e, tat_now;

    assign load_en   = ctl.load && !started_reg && (loaded_reg < CW'(MAX_JOBS));
    assign scan_more = scan_idx_reg < loaded_reg;
    assign win_hit   = pend_reg && (lo_incl_reg || (CT_W'(arr_q) > lo_reg))
                       && (CT_W'(arr_q) <= hi_reg);
    assign push_idx  = ctl.push_j ? j_reg : pidx_reg;
    assign push_en   = ((ctl.scan_run && win_hit) || ctl.push_j)
                       && (count_reg < CW'(MAX_JOBS));
    assign tail_sum  = (JW + 1)'(head_reg) + (JW + 1)'(count_reg);
    assign tail      = (tail_sum >= (JW + 1)'(MAX_JOBS)) ?
                       JW'(tail_sum - (JW + 1)'(MAX_JOBS)) : JW'(tail_sum);
    assign head_inc  = (head_reg == JW'(MAX_JOBS - 1)) ? '0 : head_reg + 1'b1;

    assign qe      = (quantum_reg == 16'd0) ? 16'd1 : quantum_reg;
    assign rem16   = 16'(rem_q);
    assign e       = (rem16 < qe) ? rem16 : qe;
    assign ct_e    = ct_reg + CT_W'(e);
    assign tat_now = ct_reg - CT_W'(arr_j_reg);

    always_comb
    begin
        arr_addr = '0;
        if (ctl.scan_run)
            arr_addr = scan_idx_reg[JW-1:0];
        else if (ctl.pop_j)
            arr_addr = fifo_q;
    end

    // memories
    always_ff @(posedge clk)
    begin
        arr_q  <= arr_mem[arr_addr];
        bur_q  <= bur_mem[fifo_q];
        rem_q  <= rem_mem[fifo_q];
        fifo_q <= fifo_mem[head_reg];
        if (load_en)
        begin
            arr_mem[loaded_reg[JW-1:0]] <= TW'(req_item.arr_time);
            bur_mem[loaded_reg[JW-1:0]] <= TW'(req_item.bur_time);
        end
        if (load_en)
            rem_mem[loaded_reg[JW-1:0]] <= TW'(req_item.bur_time);
        else if (ctl.slice_set)
            rem_mem[j_reg] <= rem_q - TW'(e);
        if (push_en)
            fifo_mem[tail] <= push_idx;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg   <= QUANTUM_RESET;
            ct_reg        <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            lo_incl_reg   <= 1'b0;
            started_reg   <= 1'b0;
            loaded_reg    <= '0;
            completed_reg <= '0;
            count_reg     <= '0;
            head_reg      <= '0;
            scan_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                quantum_reg <= cfg_wr_data;
            if (ctl.emit)
                out_valid_reg <= 1'b1;
            else if (!evt_stall)
                out_valid_reg <= 1'b0;

            if (ctl.clear)
            begin
                ct_reg        <= '0;
                started_reg   <= 1'b0;
                loaded_reg    <= '0;
                completed_reg <= '0;
                count_reg     <= '0;
                head_reg      <= '0;
            end
            else
            begin
                if (load_en)
                    loaded_reg <= loaded_reg + 1'b1;
                if (ctl.start_set)
                begin
                    started_reg <= 1'b1;
                    ct_reg      <= CT_W'(arr_q);
                    hi_reg      <= CT_W'(arr_q);
                    lo_incl_reg <= 1'b1;
                end
                if (ctl.idle_set)
                begin
                    lo_reg      <= ct_reg;
                    hi_reg      <= ct_reg + 1'b1;
                    ct_reg      <= ct_reg + 1'b1;
                    lo_incl_reg <= 1'b0;
                end
                if (ctl.slice_set)
                begin
                    lo_reg      <= ct_reg;
                    hi_reg      <= ct_e;
                    ct_reg      <= ct_e;
                    lo_incl_reg <= 1'b0;
                    if (rem16 <= qe)
                        completed_reg <= completed_reg + 1'b1;
                end
                if (ctl.pop_rd)
                begin
                    head_reg  <= head_inc;
                    count_reg <= count_reg - 1'b1;
                end
                else if (push_en)
                    count_reg <= count_reg + 1'b1;

                if (ctl.start_set || ctl.idle_set || ctl.slice_set)
                begin
                    scan_idx_reg <= '0;
                    pend_reg     <= 1'b0;
                end
                else if (ctl.scan_run)
                begin
                    pend_reg <= scan_more;
                    if (scan_more)
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ctl.scan_run)
            pidx_reg <= scan_idx_reg[JW-1:0];
        if (ctl.pop_j)
            j_reg <= fifo_q;
        if (ctl.slice_set)
        begin
            arr_j_reg <= arr_q;
            bur_j_reg <= bur_q;
        end
        if (ctl.tat_set)
            tat_reg <= tat_now;
        if (ctl.emit)
            out_reg <= res_reg;

        if (ctl.res_none || ctl.end_res)
        begin
            res_reg            <= '0;
            res_reg.event_kind <= ctl.res_none ? EV_NONE : EV_END;
            res_reg.event_time <= 21'(ct_reg);
        end
        else if (ctl.start_set)
        begin
            res_reg              <= '0;
            res_reg.event_kind   <= EV_IDLE;
            res_reg.slice_length <= 16'(arr_q);
        end
        else if (ctl.idle_set)
        begin
            res_reg              <= '0;
            res_reg.event_kind   <= EV_IDLE;
            res_reg.event_time   <= 21'(ct_reg);
            res_reg.slice_length <= 16'd1;
        end
        else if (ctl.slice_set)
        begin
            res_reg              <= '0;
            res_reg.event_kind   <= EV_RUN;
            res_reg.event_time   <= 21'(ct_reg);
            res_reg.job_index    <= 4'(j_reg);
            res_reg.slice_length <= e;
            res_reg.job_finished <= (rem16 <= qe);
        end
        else if (ctl.tat_set)
        begin
            res_reg.done_time <= 21'(ct_reg);
            res_reg.tat_time  <= 21'(tat_now);
        end
        else if (ctl.wt_set)
            res_reg.wait_time <= 21'(tat_reg - CT_W'(bur_j_reg));
    end

    assign sts.no_jobs   = (loaded_reg == '0);
    assign sts.started   = started_reg;
    assign sts.all_done  = (completed_reg >= loaded_reg);
    assign sts.q_empty   = (count_reg == '0);
    assign sts.start_pos = (arr_q != '0);
    assign sts.slice_fin = (rem16 <= qe);
    assign sts.scan_done = !scan_more && !pend_reg;
    assign sts.out_busy  = out_valid_reg && evt_stall;

    assign evt_valid = out_valid_reg;
    assign evt_item  = out_reg;

endmodule

/* src/round_robin_quantum_scheduler_unit.sv */
// round-robin quantum scheduler, top level
// depends on rrqs_pkg, rrqs_ctrl and rrqs_datapath
//
// usage:
//   req channel (req_valid / req_stall / req_item) takes load, step and clear items.
//   evt channel (evt_valid / evt_stall / evt_item) gives one event per step item.
//   cfg_wr_en / cfg_wr_data write the time quantum; the user must write it only
//   while the block is idle, as the block itself does not enforce this.
// timing:
//   load and clear give no event. a step runs the arrival scan over the jobs loaded,
//   except with no jobs loaded and for the end event. the first step scans twice
//   when job 0 arrives at time 0. one item is worked on at a time; req_stall is
//   high until the step's event sits in the output register.
// reset:
//   clears the job count, queue, time and schedule state; quantum goes to 2.
//   job tables hold no reset value and are read only after a load.
// stall:
//   a held event keeps evt_valid and its payload; the next item is still
//   taken, and its event waits until the output register is free.
module round_robin_quantum_scheduler_unit #(
    parameter int MAX_JOBS  = 16,
    parameter int TIME_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  rrqs_pkg::req_item_t req_item,
    output logic                evt_valid,
    input  logic                evt_stall,
    output rrqs_pkg::evt_item_t evt_item,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data
);
    import rrqs_pkg::*;

    ctl_t ctl;
    sts_t sts;

    rrqs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_opcode (req_item.opcode),
        .sts        (sts),
        .req_stall  (req_stall),
        .ctl        (ctl)
    );

    rrqs_datapath #(
        .MAX_JOBS  (MAX_JOBS),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_item    (req_item),
        .ctl         (ctl),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .evt_stall   (evt_stall),
        .sts         (sts),
        .evt_valid   (evt_valid),
        .evt_item    (evt_item)
    );

endmodule

/* src/rrqs_checker.sv */
// port-level assertions for the round-robin quantum scheduler, with its bind
// depends on rrqs_pkg and round_robin_quantum_scheduler_unit_macros.svh
`include "round_robin_quantum_scheduler_unit_macros.svh"

module rrqs_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                evt_valid,
    input logic                evt_stall,
    input rrqs_pkg::evt_item_t evt_item
);
    import rrqs_pkg::*;

    `RRQS_ASSERT_NEXT(a_evt_hold, evt_valid && evt_stall, evt_valid && $stable(evt_item), "event changed while stalled")
    `RRQS_ASSERT_NOW(a_job_idx, evt_valid && (evt_item.event_kind != EV_RUN), (evt_item.job_index == 4'd0) && !evt_item.job_finished, "non-run event carries job data")
    `RRQS_ASSERT_NOW(a_fin_zero, evt_valid && !evt_item.job_finished, (evt_item.done_time == 21'd0) && (evt_item.tat_time == 21'd0) && (evt_item.wait_time == 21'd0), "completion data without finish")
    `RRQS_ASSERT_NOW(a_fin_order, evt_valid && evt_item.job_finished, (evt_item.wait_time <= evt_item.tat_time) && (evt_item.tat_time <= evt_item.done_time), "finish times out of order")

endmodule

bind round_robin_quantum_scheduler_unit rrqs_checker u_rrqs_checker (.*);

/* test/tb_top.sv */
// testbench for the round-robin quantum scheduler unit
// depends on rrqs_pkg and round_robin_quantum_scheduler_unit
// directed table then random job sets, checked against an in-bench scheduler model
`timescale 1ns / 1ps

module tb_top;
    import rrqs_pkg::*;

    localparam int NJOBS = 16;
    localparam int TIMEOUT_CYCLES = 1500000;

    typedef struct packed {
        logic        has_evt;
        req_item_t   req;
        evt_item_t   evt;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_item_t   req_item = '0;
    logic        evt_valid;
    logic        evt_stall = 1'b0;
    evt_item_t   evt_item;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    round_robin_quantum_scheduler_unit dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
        .evt_valid(evt_valid), .evt_stall(evt_stall), .evt_item(evt_item),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always #5 clk = ~clk;

    // scheduler model state
    logic [15:0] quantum;
    logic [15:0] arr [NJOBS];
    logic [15:0] bur [NJOBS];
    logic [15:0] rem [NJOBS];
    logic [3:0]  rq [$];
    logic [20:0] now;
    int          loaded;
    int          done_cnt;
    logic        started;

    evt_item_t   pending_events [$];
    int          errors = 0;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        hold_off = 1'b0;

    function automatic void sched_clear();
        rq.delete();
        now = '0;
        loaded = 0;
        done_cnt = 0;
        started = 1'b0;
    endfunction

    function automatic evt_item_t sched_event();
        evt_item_t  e;
        logic [15:0] q;
        logic [15:0] run;
        logic [20:0] t0;
        logic [20:0] tat;
        int          j;
        e = '0;
        e.event_time = now;
        if (loaded == 0)
        begin
            e.event_kind = EV_NONE;
            return e;
        end
        if (!started)
        begin
            started = 1'b1;
            now = 21'(arr[0]);
            for (int i = 0; i < loaded; i++)
                if (arr[i] <= arr[0] && rq.size() < NJOBS)
                    rq.push_back(4'(i));
            if (arr[0] > 0)
            begin
                e.event_kind = EV_IDLE;
                e.event_time = '0;
                e.slice_length = arr[0];
                return e;
            end
        end
        if (done_cnt >= loaded)
        begin
            e.event_kind = EV_END;
            return e;
        end
        if (rq.size() == 0)
        begin
            e.event_kind = EV_IDLE;
            e.slice_length = 16'd1;
            now = now + 21'd1;
            for (int i = 0; i < loaded; i++)
                if (21'(arr[i]) == now && rq.size() < NJOBS)
                    rq.push_back(4'(i));
            return e;
        end
        j = rq.pop_front();
        q = (quantum == 0) ? 16'd1 : quantum;
        run = (rem[j] < q) ? rem[j] : q;
        t0 = now;
        now = now + 21'(run);
        rem[j] = rem[j] - run;
        e.event_kind = EV_RUN;
        e.job_index = 4'(j);
        e.slice_length = run;
        for (int i = 0; i < loaded; i++)
            if (21'(arr[i]) > t0 && 21'(arr[i]) <= now && rq.size() < NJOBS)
                rq.push_back(4'(i));
        if (rem[j] > 0)
        begin
            if (rq.size() < NJOBS)
                rq.push_back(4'(j));
        end
        else
        begin
            tat = now - 21'(arr[j]);
            e.job_finished = 1'b1;
            e.done_time = now;
            e.tat_time = tat;
            e.wait_time = tat - 21'(bur[j]);
            done_cnt++;
        end
        return e;
    endfunction

    function automatic void sched_accept(req_item_t r);
        if (r.opcode == OP_LOAD)
        begin
            if (!started && loaded < NJOBS)
            begin
                arr[loaded] = r.arr_time;
                bur[loaded] = r.bur_time;
                rem[loaded] = r.bur_time;
                loaded++;
            end
        end
        else if (r.opcode == OP_CLEAR)
            sched_clear();
        else if (r.opcode == OP_STEP)
            pending_events.push_back(sched_event());
    endfunction

    task automatic send_item(req_item_t r);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_item <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sched_accept(r);
        @(negedge clk);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_quantum(logic [15:0] v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        quantum = v;
    endtask

    function automatic req_item_t mk(logic [1:0] op, logic [15:0] a, logic [15:0] b);
        req_item_t r;
        r.opcode = op;
        r.arr_time = a;
        r.bur_time = b;
        return r;
    endfunction

    // mostly sorted arrivals, mostly small bursts; a few large values
    task automatic random_job_set(int steps);
        int          n;
        logic [15:0] a;
        logic [15:0] b;
        n = $urandom_range(NJOBS, 1);
        a = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4));
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(19) == 0)
                b = 16'($urandom);
            else
                b = 16'($urandom_range(8));
            send_item(mk(OP_LOAD, a, b));
            if ($urandom_range(3) != 0)
                a = a + 16'($urandom_range(5));
            else if ($urandom_range(30) == 0)
                a = 16'($urandom);
        end
        for (int s = 0; s < steps; s++)
        begin
            case ($urandom_range(39))
                0: send_item(mk(OP_LOAD, 16'($urandom), 16'($urandom)));
                1: send_item(mk(OP_RSVD, 16'($urandom), 16'($urandom)));
                default: send_item(mk(OP_STEP, 16'($urandom), 16'($urandom)));
            endcase
        end
        send_item(mk(OP_CLEAR, 16'($urandom), 16'($urandom)));
    endtask

    // event checking
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && evt_valid && !evt_stall)
        begin
            if (pending_events.size() == 0)
            begin
                $error("unexpected event item %h", evt_item);
                errors++;
            end
            else
            begin
                evt_item_t x;
                x = pending_events.pop_front();
                if (evt_item.event_kind !== x.event_kind)
                begin
                    $error("event_kind exp %0d got %0d", x.event_kind, evt_item.event_kind);
                    errors++;
                end
                if (evt_item.event_time !== x.event_time)
                begin
                    $error("event_time exp %0d got %0d", x.event_time, evt_item.event_time);
                    errors++;
                end
                if (evt_item.job_index !== x.job_index)
                begin
                    $error("job_index exp %0d got %0d", x.job_index, evt_item.job_index);
                    errors++;
                end
                if (evt_item.slice_length !== x.slice_length)
                begin
                    $error("slice_length exp %0d got %0d", x.slice_length,
                           evt_item.slice_length);
                    errors++;
                end
                if (evt_item.job_finished !== x.job_finished)
                begin
                    $error("job_finished exp %0d got %0d", x.job_finished,
                           evt_item.job_finished);
                    errors++;
                end
                if (evt_item.done_time !== x.done_time)
                begin
                    $error("done_time exp %0d got %0d", x.done_time,
                           evt_item.done_time);
                    errors++;
                end
                if (evt_item.tat_time !== x.tat_time)
                begin
                    $error("tat_time exp %0d got %0d", x.tat_time,
                           evt_item.tat_time);
                    errors++;
                end
                if (evt_item.wait_time !== x.wait_time)
                begin
                    $error("wait_time exp %0d got %0d", x.wait_time,
                           evt_item.wait_time);
                    errors++;
                end
            end
        end
        if (cycles > TIMEOUT_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver stall
    always @(negedge clk)
    begin
        if (hold_off)
            evt_stall <= 1'b1;
        else
            evt_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end

    dir_row_t dir_rows [$];

    function automatic evt_item_t ev_make(logic [1:0] k, logic [20:0] t, logic [3:0] j,
                                          logic [15:0] s, logic f, logic [20:0] c,
                                          logic [20:0] ta, logic [20:0] w);
        evt_item_t e;
        e = '{k, t, j, s, f, c, ta, w};
        return e;
    endfunction

    initial
    begin
        quantum = QUANTUM_RESET;
        sched_clear();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 19;
        recv_idle_pct = 84;

        // directed rows: step with nothing loaded, extremes, zero burst, late start
        dir_rows.push_back('{1'b1, mk(OP_STEP, 16'hffff, 16'hffff),
                             ev_make(EV_NONE, 0, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{1'b0, mk(OP_LOAD, 16'd0, 16'd0), '0});
        dir_rows.push_back('{1'b0, mk(OP_LOAD, 16'd0, 16'd3), '0});
        dir_rows.push_back('{1'b1, mk(OP_STEP, 0, 0), ev_make(EV_RUN, 0, 0, 0, 1, 0, 0, 0)});
        dir_rows.push_back('{1'b1, mk(OP_STEP, 0, 0), '0});
        dir_rows.push_back('{1'b0, mk(OP_LOAD, 16'd5, 16'd5), '0});
        dir_rows.push_back('{1'b1, mk(OP_STEP, 0, 0), '0});
        dir_rows.push_back('{1'b1, mk(OP_STEP, 0, 0), '0});
        dir_rows.push_back('{1'b1, mk(OP_STEP, 0, 0), '0});
        dir_rows.push_back('{1'b0, mk(OP_RSVD, 16'hffff, 16'hffff), '0});
        dir_rows.push_back('{1'b0, mk(OP_CLEAR, 0, 0), '0});
        dir_rows.push_back('{1'b0, mk(OP_LOAD, 16'hffff, 16'hffff), '0});
        dir_rows.push_back('{1'b0, mk(OP_LOAD, 16'hffff, 16'd1), '0});
        dir_rows.push_back('{1'b1, mk(OP_STEP, 0, 0),
                             ev_make(EV_IDLE, 0, 0, 16'hffff, 0, 0, 0, 0)});
        dir_rows.push_back('{1'b1, mk(OP_STEP, 0, 0), '0});
        dir_rows.push_back('{1'b1, mk(OP_STEP, 0, 0), '0});
        dir_rows.push_back('{1'b1, mk(OP_STEP, 0, 0), '0});
        dir_rows.push_back('{1'b0, mk(OP_CLEAR, 0, 0), '0});
        dir_rows.push_back('{1'b0, mk(OP_LOAD, 16'd2, 16'd1), '0});
        dir_rows.push_back('{1'b0, mk(OP_LOAD, 16'd7, 16'd1), '0});
        for (int i = 0; i < 5; i++)
            dir_rows.push_back('{1'b1, mk(OP_STEP, 0, 0), '0});
        dir_rows.push_back('{1'b0, mk(OP_CLEAR, 0, 0), '0});

        foreach (dir_rows[i])
        begin
            send_item(dir_rows[i].req);
            if (dir_rows[i].has_evt && dir_rows[i].evt != '0
                && pending_events[$] != dir_rows[i].evt)
            begin
                $error("directed row %0d table entry disagrees with model", i);
                errors++;
            end
        end

        write_quantum(16'd0);
        random_job_set(30);
        write_quantum(16'hffff);
        random_job_set(30);
        write_quantum(16'd1);

        for (int k = 0; k < 16; k++)
            random_job_set(40);
        write_quantum(16'd3);

        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(negedge clk);
                hold_off = 1'b0;
            end
            random_job_set(20);
        join
        drain();

        send_idle_pct = 84;
        recv_idle_pct = 19;
        for (int k = 0; k < 12; k++)
            random_job_set(40);
        write_quantum(16'($urandom_range(6, 1)));

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int k = 0; k < 12; k++)
        begin
            random_job_set(40);
            if (k == 6)
                write_quantum(16'hffff);
        end
        write_quantum(16'd2);
        random_job_set(40);

        drain();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

/* files.f */
+incdir+src
src/rrqs_pkg.sv
src/rrqs_ctrl.sv
src/rrqs_datapath.sv
src/round_robin_quantum_scheduler_unit.sv
src/rrqs_checker.sv
test/tb_top.sv
